FILE: hw/rtl/rsdc_pkg.sv
// ---------------------------------------------------------------------------
// rsdc_pkg
// types and codes shared by the rs485 direction controller and its checker
// ---------------------------------------------------------------------------
package rsdc_pkg;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam int unsigned TICKS_BITS     = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LINE_MODE      = 2'd0,
        CFG_TURN_ON_TICKS  = 2'd1,
        CFG_TURN_OFF_TICKS = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_TICK          = 3'd0,
        EV_START_TX      = 3'd1,
        EV_STOP_TX       = 3'd2,
        EV_LINE_WRITE    = 3'd3,
        EV_FORMAT_CHANGE = 3'd4,
        EV_DATA_WRITTEN  = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        LM_PASS      = 3'd0,
        LM_RS485_HI  = 3'd1,
        LM_RS485_LO  = 3'd2,
        LM_MODEM     = 3'd3,
        LM_MODEM_DCD = 3'd4
    } t_line_mode;

    typedef enum logic [2:0] {
        ST_RECEIVE      = 3'd0,
        ST_CARRIER_WAIT = 3'd1,
        ST_ON_DELAY     = 3'd2,
        ST_CTS_WAIT     = 3'd3,
        ST_TRANSMIT     = 3'd4,
        ST_OFF_DELAY    = 3'd5
    } t_dir_state;

    typedef struct packed {
        logic [2:0] mode;
        logic       cts;
        logic       dcd;
        logic       tx_idle;
        logic       rts_request;
    } t_in_beat;

    typedef struct packed {
        logic       rts_level;
        logic       hold_tx;
        logic       start_pulse;
        logic       stop_pulse;
        logic [2:0] line_state;
    } t_out_beat;

endpackage

FILE: hw/rtl/rs485_direction_control.sv
// ---------------------------------------------------------------------------
// rs485_direction_control
// driver enable / rts sequencer for a half-duplex rs485 or multidrop modem uart
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      i_in_valid / o_in_stall    t_in_beat (event and line levels)
//  out       output     o_out_valid / i_out_stall  t_out_beat (rts, hold, pulses, state)
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one event beat per clock while o_in_stall is low; each accepted beat gives its result beat in the next cycle
//  the whole event update is one pass of logic into the state and result registers
//  o_in_stall rises only while a result beat sits in the output register stalled
//  synchronous reset: receive state, timer idle, rts low, pass-through mode
//  cfg writes are always taken (o_cfg_ready is high)
module rs485_direction_control #(
    parameter int unsigned DELAY_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  rsdc_pkg::t_in_beat                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output rsdc_pkg::t_out_beat                  o_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rsdc_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [rsdc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam logic [32:0] CNT_MAX = (33'd1 << DELAY_BITS) - 33'd1;
    localparam logic [DELAY_BITS-1:0] POLL_TICKS = {{(DELAY_BITS-1){1'b0}}, 1'b1};

    rsdc_pkg::t_line_mode                r_line_mode;
    logic [rsdc_pkg::TICKS_BITS-1:0]     r_on_ticks;
    logic [rsdc_pkg::TICKS_BITS-1:0]     r_off_ticks;
    rsdc_pkg::t_dir_state                r_state, n_state;
    logic [DELAY_BITS-1:0]               r_cnt, n_cnt;
    logic                                r_hold, n_hold;
    logic                                r_rts, n_rts;
    logic                                n_start, n_stop;
    rsdc_pkg::t_out_beat                 r_out, n_out;
    logic                                r_out_valid;

    logic                                in_accept;
    logic                                cfg_write;
    logic                                managed;
    logic                                rs485_mode;
    logic                                do_expire, do_turn_on, do_on_done;
    rsdc_pkg::t_event                    ev;
    rsdc_pkg::t_line_mode                cfg_mode;
    logic                                cfg_mode_switch;

    function automatic logic [DELAY_BITS-1:0] f_sat(input logic [rsdc_pkg::TICKS_BITS-1:0] t);
        logic [32:0] w;
        w = {{(33-rsdc_pkg::TICKS_BITS){1'b0}}, t};
        if (w > CNT_MAX) begin
            return CNT_MAX[DELAY_BITS-1:0];
        end
        return w[DELAY_BITS-1:0];
    endfunction

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign managed    = (r_line_mode >= rsdc_pkg::LM_RS485_HI) &&
                        (r_line_mode <= rsdc_pkg::LM_MODEM_DCD);
    assign rs485_mode = (r_line_mode == rsdc_pkg::LM_RS485_HI) ||
                        (r_line_mode == rsdc_pkg::LM_RS485_LO);
    assign ev         = rsdc_pkg::t_event'(i_in.mode);

    assign cfg_mode        = rsdc_pkg::t_line_mode'(i_cfg_data[2:0]);
    assign cfg_mode_switch = cfg_write &&
                             (i_cfg_index == rsdc_pkg::CFG_LINE_MODE) &&
                             (cfg_mode <= rsdc_pkg::LM_MODEM_DCD) &&
                             (cfg_mode != r_line_mode);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_hold     = r_hold;
        n_rts      = r_rts;
        n_start    = 1'b0;
        n_stop     = 1'b0;
        do_expire  = 1'b0;
        do_turn_on = 1'b0;
        do_on_done = 1'b0;

        // event
        case (ev)
            rsdc_pkg::EV_TICK: begin
                if (r_cnt != '0) begin
                    n_cnt     = r_cnt - POLL_TICKS;
                    do_expire = (n_cnt == '0);
                end
            end
            rsdc_pkg::EV_START_TX: begin
                n_start = 1'b1;
                if (managed) begin
                    case (r_state)
                        rsdc_pkg::ST_RECEIVE: begin
                            if (r_line_mode == rsdc_pkg::LM_MODEM_DCD) begin
                                n_state   = rsdc_pkg::ST_CARRIER_WAIT;
                                n_hold    = 1'b1;
                                n_stop    = 1'b1;
                                do_expire = 1'b1;
                            end else begin
                                n_start    = 1'b0;
                                do_turn_on = 1'b1;
                            end
                        end
                        rsdc_pkg::ST_ON_DELAY: begin
                            n_start = 1'b0;
                        end
                        rsdc_pkg::ST_OFF_DELAY: begin
                            n_cnt   = '0;
                            n_state = rsdc_pkg::ST_TRANSMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rsdc_pkg::EV_STOP_TX: begin
                n_stop = 1'b1;
                if (managed) begin
                    n_hold  = 1'b0;
                    n_rts   = (r_line_mode == rsdc_pkg::LM_RS485_LO);
                    n_state = rsdc_pkg::ST_RECEIVE;
                end
            end
            rsdc_pkg::EV_LINE_WRITE: begin
                if (r_line_mode == rsdc_pkg::LM_RS485_LO) begin
                    n_rts = (r_state == rsdc_pkg::ST_RECEIVE);
                end else if (managed) begin
                    n_rts = (r_state != rsdc_pkg::ST_RECEIVE);
                end else begin
                    n_rts = i_in.rts_request;
                end
            end
            rsdc_pkg::EV_FORMAT_CHANGE: begin
                if (managed) begin
                    n_hold  = 1'b0;
                    n_rts   = (r_line_mode == rsdc_pkg::LM_RS485_LO);
                    n_state = rsdc_pkg::ST_RECEIVE;
                end
            end
            rsdc_pkg::EV_DATA_WRITTEN: begin
                if (managed) begin
                    n_state = rsdc_pkg::ST_TRANSMIT;
                    n_cnt   = POLL_TICKS;
                end
            end
            default: begin
            end
        endcase

        // timer expiry
        if (do_expire) begin
            case (n_state)
                rsdc_pkg::ST_CARRIER_WAIT: begin
                    if (!i_in.dcd) begin
                        do_turn_on = 1'b1;
                    end else begin
                        n_cnt = POLL_TICKS;
                    end
                end
                rsdc_pkg::ST_ON_DELAY: begin
                    do_on_done = 1'b1;
                end
                rsdc_pkg::ST_CTS_WAIT: begin
                    if (i_in.cts) begin
                        n_state = rsdc_pkg::ST_TRANSMIT;
                        n_hold  = 1'b0;
                        n_start = 1'b1;
                    end else begin
                        n_cnt = POLL_TICKS;
                    end
                end
                rsdc_pkg::ST_OFF_DELAY: begin
                    n_hold  = 1'b0;
                    n_rts   = (r_line_mode == rsdc_pkg::LM_RS485_LO);
                    n_state = rsdc_pkg::ST_RECEIVE;
                end
                rsdc_pkg::ST_TRANSMIT: begin
                    if (!n_hold && i_in.tx_idle) begin
                        if (r_off_ticks != '0) begin
                            n_state = rsdc_pkg::ST_OFF_DELAY;
                            n_cnt   = f_sat(r_off_ticks);
                        end else begin
                            n_hold  = 1'b0;
                            n_rts   = (r_line_mode == rsdc_pkg::LM_RS485_LO);
                            n_state = rsdc_pkg::ST_RECEIVE;
                        end
                    end else begin
                        n_cnt = POLL_TICKS;
                    end
                end
                default: begin
                end
            endcase
        end

        // driver turn-on
        if (do_turn_on) begin
            n_rts   = (r_line_mode != rsdc_pkg::LM_RS485_LO);
            n_state = rsdc_pkg::ST_ON_DELAY;
            if (r_on_ticks != '0) begin
                n_cnt = f_sat(r_on_ticks);
            end else begin
                do_on_done = 1'b1;
            end
        end

        // turn-on delay done
        if (do_on_done) begin
            if (rs485_mode || i_in.cts) begin
                n_state = rsdc_pkg::ST_TRANSMIT;
                n_hold  = 1'b0;
                n_start = 1'b1;
            end else begin
                n_state = rsdc_pkg::ST_CTS_WAIT;
                n_cnt   = POLL_TICKS;
            end
        end

        n_out.rts_level   = n_rts;
        n_out.hold_tx     = n_hold;
        n_out.start_pulse = n_start;
        n_out.stop_pulse  = n_stop;
        n_out.line_state  = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= rsdc_pkg::LM_PASS;
            r_on_ticks  <= '0;
            r_off_ticks <= '0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                rsdc_pkg::CFG_LINE_MODE: begin
                    if (cfg_mode_switch) begin
                        r_line_mode <= cfg_mode;
                    end
                end
                rsdc_pkg::CFG_TURN_ON_TICKS: begin
                    r_on_ticks <= i_cfg_data;
                end
                rsdc_pkg::CFG_TURN_OFF_TICKS: begin
                    r_off_ticks <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsdc_pkg::ST_RECEIVE;
            r_cnt   <= '0;
            r_hold  <= 1'b0;
            r_rts   <= 1'b0;
        end else if (cfg_mode_switch) begin
            if (cfg_mode != rsdc_pkg::LM_PASS) begin
                r_state <= rsdc_pkg::ST_RECEIVE;
                r_hold  <= 1'b0;
                r_rts   <= (cfg_mode == rsdc_pkg::LM_RS485_LO);
            end
        end else if (in_accept) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_hold  <= n_hold;
            r_rts   <= n_rts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: hw/rtl/rsdc_checker.sv
// ---------------------------------------------------------------------------
// rsdc_checker
// port-level checks for the rs485 direction controller
// ---------------------------------------------------------------------------
module rsdc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input rsdc_pkg::t_out_beat  o_out
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result beat changed");

    // every accepted event beat gives a result beat next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted beat without result");

    // receive reached only through driver release, reset or a mode switch, all of which drop the hold
    a_receive_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.line_state == rsdc_pkg::ST_RECEIVE)) |-> !o_out.hold_tx)
        else $error("hold set in receive state");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result beat after reset");

endmodule

bind rs485_direction_control rsdc_checker u_rsdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
